@@ hdl/apu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package apu_pkg;

  localparam int GradW  = 32;
  localparam int DecayW = 16;
  localparam int RateW  = 31;
  localparam int EpsW   = 25;

  typedef enum logic [1:0] {
    MODE_HID_BIAS = 2'd0,
    MODE_CLS_BIAS = 2'd1,
    MODE_IN_HID   = 2'd2,
    MODE_HID_CLS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DECAY_FIRST    = 2'd0,
    REG_DECAY_SECOND   = 2'd1,
    REG_CORRECTED_RATE = 2'd2,
    REG_STABILITY_TERM = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DecayW-1:0] decay_first;
    logic [DecayW-1:0] decay_second;
    logic [RateW-1:0]  corrected_rate;
    logic [EpsW-1:0]   stability_term;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [9:0]       visible_index;
    logic [7:0]       hidden_index;
    logic [3:0]       class_index;
    logic [GradW-1:0] grad;
  } in_word_t;

  typedef struct packed {
    logic [GradW-1:0] delta;
    logic             saturated;
  } out_word_t;

  // Quotient bits: rate (31b) * |m| (32b) can reach 63 bits.
  localparam int NumW = 63;
  localparam int DenW = 33;

endpackage
`default_nettype wire

@@ hdl/apu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface apu_in_if;
  import apu_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apu_out_if;
  import apu_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/apu_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage, fully pipelined.
// Carries sign and a valid bit along; stalls as a whole with en.
module apu_divider
  import apu_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire logic [NumW-1:0] in_num,
  input  wire logic [DenW-1:0] in_den,
  input  wire logic            in_neg,
  input  wire logic            in_zero,
  output logic                 out_vld,
  output logic [NumW-1:0]      out_quo,
  output logic                 out_neg,
  output logic                 out_zero
);

  logic [NumW:0]       vld_r;
  logic [NumW-1:0]     num_r  [NumW+1];
  logic [DenW:0]       rem_r  [NumW+1];
  logic [DenW-1:0]     den_r  [NumW+1];
  logic [NumW:0]       neg_r;
  logic [NumW:0]       zero_r;

  always_comb begin
    vld_r[0]  = in_vld;
    num_r[0]  = in_num;
    rem_r[0]  = '0;
    den_r[0]  = in_den;
    neg_r[0]  = in_neg;
    zero_r[0] = in_zero;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] sh;
    logic [DenW+1:0] diff;
    logic            ge;
    always_comb begin
      sh   = {rem_r[s], num_r[s][NumW-1]};
      diff = sh - {2'b00, den_r[s]};
      ge   = !diff[DenW+1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? diff[DenW:0] : sh[DenW:0];
        num_r[s+1]  <= {num_r[s][NumW-2:0], ge};
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  assign out_vld  = vld_r[NumW];
  assign out_quo  = num_r[NumW];
  assign out_neg  = neg_r[NumW];
  assign out_zero = zero_r[NumW];

endmodule
`default_nettype wire

@@ hdl/apu_moment_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Moment memory with registered read, read-modify-write, forwarding of the
// newest write, and an epoch-free clear sweep after reset.
module apu_moment_store #(
  parameter int AddrW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  output logic                  clr_busy,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic [63:0]           rd_data,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [63:0]      wr_data
);

  logic [63:0]      mem [2**AddrW];
  logic [63:0]      q_r;
  logic [AddrW:0]   clr_cnt_r;
  logic             fwd_r;
  logic [63:0]      fwd_data_r;

  assign clr_busy = !clr_cnt_r[AddrW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_cnt_r[AddrW-1:0]] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule
`default_nettype wire

@@ hdl/adamax_param_update_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Adamax step engine: accepts one word per cycle and returns one delta per
// word in order. A word taken at a clock edge passes the memory read, the
// update, the magnitude and denominator stage and the multiply, then
// a 63-stage restoring divider and the output register. Backpressure on the
// output stalls the whole pipe, so throughput is one word per cycle while
// the output is ready. First and second moments of all four tables sit in
// one merged memory (m,v per entry); back-to-back hits on the same entry are
// resolved by forwarding the write-back data into the read. After reset a
// clear sweep zeroes all 2**ceil(log2(total entries)) entries (524288 at the
// default sizes), one entry per cycle; no word is taken until it
// ends. Configuration writes are taken at any time.
module adamax_param_update_top
  import apu_pkg::*;
#(
  parameter int VISIBLE_UNITS = 1024,
  parameter int HIDDEN_UNITS  = 256,
  parameter int CLASS_UNITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  apu_in_if.sink           in_ch,
  apu_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);

  localparam int HidBase = 0;
  localparam int ClsBase = HIDDEN_UNITS;
  localparam int IhBase  = ClsBase + CLASS_UNITS;
  localparam int HcBase  = IhBase + VISIBLE_UNITS * HIDDEN_UNITS;
  localparam int Total   = HcBase + HIDDEN_UNITS * CLASS_UNITS;
  localparam int AddrW   = $clog2(Total);

  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_first    <= 16'd58982;
      cfg_r.decay_second   <= 16'd65470;
      cfg_r.corrected_rate <= 31'd335544;
      cfg_r.stability_term <= 25'd1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DECAY_FIRST:    cfg_r.decay_first    <= cfg_wdata[DecayW-1:0];
        REG_DECAY_SECOND:   cfg_r.decay_second   <= cfg_wdata[DecayW-1:0];
        REG_CORRECTED_RATE: cfg_r.corrected_rate <= cfg_wdata[RateW-1:0];
        REG_STABILITY_TERM: cfg_r.stability_term <= cfg_wdata[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // Global stall: whole pipe advances only when the output stage can move.
  logic       en;
  logic       clr_busy;
  logic       dv_out;
  logic       out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en && !clr_busy;
  wire acc = in_ch.valid && in_ch.ready;

  // Stage 0: address decode.
  in_word_t       w;
  logic           ok;
  logic [63:0]    addr64;
  assign w = in_ch.data;
  always_comb begin
    ok = 1'b0;
    addr64 = '0;
    unique case (mode_t'(w.mode))
      MODE_HID_BIAS: begin
        ok = 32'(w.hidden_index) < HIDDEN_UNITS;
        addr64 = 64'(HidBase) + 64'(w.hidden_index);
      end
      MODE_CLS_BIAS: begin
        ok = 32'(w.class_index) < CLASS_UNITS;
        addr64 = 64'(ClsBase) + 64'(w.class_index);
      end
      MODE_IN_HID: begin
        ok = 32'(w.visible_index) < VISIBLE_UNITS && 32'(w.hidden_index) < HIDDEN_UNITS;
        addr64 = 64'(IhBase) + 64'(w.visible_index) * 64'(HIDDEN_UNITS)
                 + 64'(w.hidden_index);
      end
      MODE_HID_CLS: begin
        ok = 32'(w.hidden_index) < HIDDEN_UNITS && 32'(w.class_index) < CLASS_UNITS;
        addr64 = 64'(HcBase) + 64'(w.hidden_index) * 64'(CLASS_UNITS)
                 + 64'(w.class_index);
      end
      default: ;
    endcase
  end

  // Stage 1: memory read in flight.
  logic             s1_vld_r, s1_ok_r;
  logic [AddrW-1:0] s1_addr_r;
  logic [31:0]      s1_grad_r;
  logic [63:0]      mem_q;

  // Stage 2 (update) results, written back in same cycle they register.
  logic             s2_vld_r, s2_ok_r;
  logic [31:0]      s2_m_r, s2_v_r;
  logic [31:0]      m_cur, v_cur;
  logic [31:0]      m_nxt, v_nxt;
  logic             wr_en;

  assign wr_en = en && s1_vld_r && s1_ok_r;

  apu_moment_store #(.AddrW(AddrW)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .rd_en    (en),
    .rd_addr  (addr64[AddrW-1:0]),
    .rd_data  (mem_q),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr_r),
    .wr_data  ({m_nxt, v_nxt})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= acc;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok_r   <= ok;
      s1_addr_r <= addr64[AddrW-1:0];
      s1_grad_r <= w.grad;
    end
  end

  // Memory forwards writes issued in the read cycle; this covers the
  // update issued while the read was registered (from the word just ahead).
  always_comb begin
    m_cur = mem_q[63:32];
    v_cur = mem_q[31:0];
  end

  logic signed [49:0] macc;
  logic [49:0]        mrnd;
  logic [47:0]        vprod;
  logic [32:0]        vd;
  logic [31:0]        absg;
  always_comb begin
    macc = 50'(signed'({1'b0, cfg_r.decay_first})) * 50'(signed'(m_cur))
         + 50'(signed'({1'b0, 17'h10000 - {1'b0, cfg_r.decay_first}}))
           * 50'(signed'(s1_grad_r));
    mrnd = macc + 50'sd32768;
    m_nxt = mrnd[47:16];
    vprod = 48'(cfg_r.decay_second) * 48'(v_cur);
    vd = 33'((vprod + 48'd32768) >> 16);
    absg = s1_grad_r[31] ? 32'(-s1_grad_r) : s1_grad_r;
    v_nxt = (vd > 33'(absg)) ? vd[31:0] : absg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ok_r   <= s1_ok_r;
      s2_m_r    <= m_nxt;
      s2_v_r    <= v_nxt;
    end
  end

  // Stage 3: magnitude and denominator.
  logic        s3_vld_r, s3_ok_r, s3_neg_r;
  logic [31:0] s3_mag_r;
  logic [DenW-1:0] s3_den_r;
  logic [DenW-1:0] den_sum;
  assign den_sum = 33'(s2_v_r) + 33'(cfg_r.stability_term);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_ok_r  <= s2_ok_r;
      s3_neg_r <= s2_m_r[31];
      s3_mag_r <= s2_m_r[31] ? 32'(-s2_m_r) : s2_m_r;
      s3_den_r <= (den_sum == '0) ? DenW'(1) : den_sum;
    end
  end

  // Stage 4: numerator product.
  logic            s4_vld_r, s4_ok_r, s4_neg_r;
  logic [NumW-1:0] s4_num_r;
  logic [DenW-1:0] s4_den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_ok_r  <= s3_ok_r;
      s4_neg_r <= s3_neg_r;
      s4_num_r <= NumW'(cfg_r.corrected_rate) * NumW'(s3_mag_r);
      s4_den_r <= s3_den_r;
    end
  end

  logic [NumW-1:0] quo;
  logic            dv_neg, dv_zero;
  apu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s4_vld_r),
    .in_num   (s4_num_r),
    .in_den   (s4_den_r),
    .in_neg   (s4_neg_r),
    .in_zero  (!s4_ok_r),
    .out_vld  (dv_out),
    .out_quo  (quo),
    .out_neg  (dv_neg),
    .out_zero (dv_zero)
  );

  // Output register: saturate and sign.
  out_word_t out_r;
  logic [31:0] dlt;
  logic        sat;
  always_comb begin
    sat = 1'b0;
    dlt = '0;
    if (dv_zero) begin
      dlt = '0;
    end else if (!dv_neg) begin
      sat = quo > NumW'(32'h7FFF_FFFF);
      dlt = sat ? 32'h7FFF_FFFF : quo[31:0];
    end else begin
      sat = quo > NumW'(32'h8000_0000);
      dlt = sat ? 32'h8000_0000 : 32'(-quo[31:0]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_out;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.delta     <= dlt;
      out_r.saturated <= sat;
    end
  end
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output word changed under stall");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ch.ready)
    else $error("word taken during clear sweep");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> s1_vld_r && !clr_busy)
    else $error("write-back without a word");

endmodule
`default_nettype wire
